@@ hw/rtl/oaht_pkg.sv @@
// shared types and constants for the open-addressing hash table
// no dependencies; used by the interfaces, the table and its checker
package oaht_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int KEY_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int KEY_BYTES   = KEY_W / BYTE_W;
    localparam int BYTE_IDX_W  = $clog2(KEY_BYTES);

    // djb2 over four bytes fits 33 bits
    localparam int HASH_W      = 33;
    localparam int HASH_CNT_W  = $clog2(HASH_W + 1);
    localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);

    // count saturation
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_PROBE_MODE  = 1'b0;
    localparam logic REG_TABLE_SLOTS = 1'b1;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // probe modes
    localparam logic PROBE_LINEAR    = 1'b0;
    localparam logic PROBE_QUADRATIC = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

endpackage

@@ hw/rtl/oaht_req_if.sv @@
// request channel of the hash table: valid/ready with mode and key
// depends on oaht_pkg
interface oaht_req_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic signed [oaht_pkg::KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

@@ hw/rtl/oaht_rsp_if.sv @@
// result channel of the hash table: valid/ready with status, slot, probes, count
// depends on oaht_pkg
interface oaht_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [oaht_pkg::SLOT_W-1:0]  slot;
    logic [oaht_pkg::CNT_W-1:0]   probes;
    logic [oaht_pkg::CNT_W-1:0]   stored_count;

    modport source (output valid, output status, output slot, output probes,
                    output stored_count, input ready);
    modport sink   (input valid, input status, input slot, input probes,
                    input stored_count, output ready);
endinterface

@@ hw/rtl/oaht_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/open_addressing_hash_table.sv @@
// Open-addressing hash table of nonzero 32-bit keys, 1024 slots of one ram.
// After reset the block sweeps the ram to empty, one slot a cycle, so it takes
// no item until the sweep is done (configuration writes are taken at once).
// A zero key goes straight to the result; any other item passes these steps:
// b key bytes hashed one a cycle (up to 4, stopping early at a zero byte), the
// bit-serial remainder unit that reduces the hash modulo the slot count, one
// ram read, and then one slot examined a cycle (p occupied slots plus the last,
// or n slots when the table is full), the slot rate
// set by the single ram read port. One item is worked at a time; a finished
// result waits in the output register while the next item is taken.
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_ram
module open_addressing_hash_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [oaht_pkg::PADDR_W-1:0]     paddr,
    input  logic [oaht_pkg::PDATA_W-1:0]     pwdata,
    output logic [oaht_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    oaht_req_if.sink                         req,
    oaht_rsp_if.source                       rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [oaht_pkg::SLOT_W-1:0]     clr_cnt_reg;

    // configuration registers
    logic                            probe_mode_reg;
    logic [oaht_pkg::CNT_W-1:0]      table_slots_reg;

    // item working registers
    logic                            mode_reg;
    logic [oaht_pkg::KEY_W-1:0]      key_reg;
    logic [oaht_pkg::KEY_W-1:0]      key_sh_reg;
    logic [oaht_pkg::BYTE_IDX_W-1:0] byte_cnt_reg;
    logic [oaht_pkg::HASH_W-1:0]     hash_reg;
    logic [oaht_pkg::HASH_CNT_W-1:0] mod_cnt_reg;
    logic [oaht_pkg::CNT_W-1:0]      rem_reg;
    logic [oaht_pkg::SLOT_W-1:0]     idx_reg;
    logic [oaht_pkg::SLOT_W-1:0]     inc_reg;
    logic [oaht_pkg::CNT_W-1:0]      step_reg;
    logic [oaht_pkg::CNT_W-1:0]      count_reg;

    // result registers
    oaht_pkg::status_t               res_status_reg;
    logic [oaht_pkg::SLOT_W-1:0]     res_slot_reg;
    logic [oaht_pkg::CNT_W-1:0]      res_probes_reg;

    // output register
    logic                            rsp_valid_reg;
    oaht_pkg::status_t               rsp_status_reg;
    logic [oaht_pkg::SLOT_W-1:0]     rsp_slot_reg;
    logic [oaht_pkg::CNT_W-1:0]      rsp_probes_reg;
    logic [oaht_pkg::CNT_W-1:0]      rsp_count_reg;

    // ram ports
    logic                            ram_we;
    logic [oaht_pkg::SLOT_W-1:0]     ram_waddr;
    logic [oaht_pkg::KEY_W-1:0]      ram_wdata;
    logic [oaht_pkg::SLOT_W-1:0]     ram_raddr;
    logic [oaht_pkg::KEY_W-1:0]      ram_rdata;

    // datapath values
    logic [oaht_pkg::CNT_W-1:0]      n_eff;
    logic                            n_is_one;
    logic [oaht_pkg::SLOT_W-1:0]     inc_first;
    logic [oaht_pkg::BYTE_W-1:0]     cur_byte;
    logic [oaht_pkg::HASH_W-1:0]     hash_next;
    logic [oaht_pkg::CNT_W-1:0]      rem_shift;
    logic [oaht_pkg::CNT_W-1:0]      rem_next;
    logic [oaht_pkg::CNT_W-1:0]      idx_sum;
    logic [oaht_pkg::SLOT_W-1:0]     idx_next;
    logic [oaht_pkg::CNT_W-1:0]      inc_sum;
    logic [oaht_pkg::SLOT_W-1:0]     inc_next;
    logic                            slot_empty;
    logic                            slot_hit;
    logic                            last_step;
    logic                            out_free;

    // apb port: always ready, register picked by the word address bit
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg  <= oaht_pkg::PROBE_LINEAR;
            table_slots_reg <= oaht_pkg::CNT_W'(oaht_pkg::TABLE_DEPTH);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                oaht_pkg::REG_PROBE_MODE:  probe_mode_reg  <= pwdata[0];
                oaht_pkg::REG_TABLE_SLOTS: table_slots_reg <= pwdata[oaht_pkg::CNT_W-1:0];
                default:                   probe_mode_reg  <= probe_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            oaht_pkg::REG_PROBE_MODE:
                prdata = {{(oaht_pkg::PDATA_W-1){1'b0}}, probe_mode_reg};
            oaht_pkg::REG_TABLE_SLOTS:
                prdata = {{(oaht_pkg::PDATA_W-oaht_pkg::CNT_W){1'b0}}, table_slots_reg};
            default:
                prdata = '0;
        endcase
    end

    // slot count in use, clamped to 1..depth
    always_comb
    begin
        if (table_slots_reg == '0)
        begin
            n_eff = oaht_pkg::CNT_W'(1);
        end
        else if (table_slots_reg > oaht_pkg::CNT_W'(oaht_pkg::TABLE_DEPTH))
        begin
            n_eff = oaht_pkg::CNT_W'(oaht_pkg::TABLE_DEPTH);
        end
        else
        begin
            n_eff = table_slots_reg;
        end
    end

    assign n_is_one  = (n_eff == oaht_pkg::CNT_W'(1));
    assign inc_first = n_is_one ? '0 : oaht_pkg::SLOT_W'(1);

    // djb2 step: h * 33 + byte
    assign cur_byte  = key_sh_reg[oaht_pkg::BYTE_W-1:0];
    assign hash_next = (hash_reg << 5) + hash_reg + oaht_pkg::HASH_W'(cur_byte);

    // bit-serial remainder step
    assign rem_shift = {rem_reg[oaht_pkg::CNT_W-2:0], hash_reg[oaht_pkg::HASH_W-1]};
    assign rem_next  = (rem_shift >= n_eff) ? rem_shift - n_eff : rem_shift;

    // next probe index and next increment, both kept below n
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, inc_reg};
    assign idx_next = (idx_sum >= n_eff) ? oaht_pkg::SLOT_W'(idx_sum - n_eff)
                                         : idx_sum[oaht_pkg::SLOT_W-1:0];
    assign inc_sum  = {1'b0, inc_reg} + oaht_pkg::CNT_W'(2);

    always_comb
    begin
        if (probe_mode_reg == oaht_pkg::PROBE_LINEAR || n_is_one)
        begin
            inc_next = inc_reg;
        end
        else if (inc_sum >= n_eff)
        begin
            inc_next = oaht_pkg::SLOT_W'(inc_sum - n_eff);
        end
        else
        begin
            inc_next = inc_sum[oaht_pkg::SLOT_W-1:0];
        end
    end

    // slot examination
    assign slot_empty = (ram_rdata == '0);
    assign slot_hit   = (mode_reg == oaht_pkg::MODE_SEARCH) && (ram_rdata == key_reg);
    assign last_step  = ((step_reg + oaht_pkg::CNT_W'(1)) == n_eff);
    assign out_free   = !rsp_valid_reg || rsp.ready;

    // ram control: clearing sweep, insert write, probe read
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = key_reg;
        ram_raddr = idx_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_CHECK)
        begin
            ram_we    = slot_empty && (mode_reg == oaht_pkg::MODE_INSERT);
            ram_raddr = idx_next;
        end
    end

    oaht_ram #(
        .WIDTH (oaht_pkg::KEY_W),
        .DEPTH (oaht_pkg::TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake outputs
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.slot         = rsp_slot_reg;
    assign rsp.probes       = rsp_probes_reg;
    assign rsp.stored_count = rsp_count_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // output register drains unless a new result is loaded
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + oaht_pkg::SLOT_W'(1);
                    if (clr_cnt_reg == oaht_pkg::SLOT_W'(oaht_pkg::TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg       <= req.mode;
                        key_reg        <= $unsigned(req.key);
                        key_sh_reg     <= $unsigned(req.key);
                        byte_cnt_reg   <= '0;
                        hash_reg       <= oaht_pkg::HASH_SEED;
                        res_status_reg <= oaht_pkg::ST_ZERO;
                        res_slot_reg   <= '0;
                        res_probes_reg <= '0;
                        if (req.key == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end

                // one key byte a cycle, stop at a zero byte
                S_HASH:
                begin
                    mod_cnt_reg <= '0;
                    rem_reg     <= '0;
                    if (cur_byte == '0)
                    begin
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        hash_reg     <= hash_next;
                        key_sh_reg   <= key_sh_reg >> oaht_pkg::BYTE_W;
                        byte_cnt_reg <= byte_cnt_reg + oaht_pkg::BYTE_IDX_W'(1);
                        if (byte_cnt_reg == oaht_pkg::BYTE_IDX_W'(oaht_pkg::KEY_BYTES - 1))
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end

                // hash modulo slot count, one bit a cycle
                S_MOD:
                begin
                    rem_reg     <= rem_next;
                    hash_reg    <= hash_reg << 1;
                    mod_cnt_reg <= mod_cnt_reg + oaht_pkg::HASH_CNT_W'(1);
                    if (mod_cnt_reg == oaht_pkg::HASH_CNT_W'(oaht_pkg::HASH_W - 1))
                    begin
                        idx_reg   <= rem_next[oaht_pkg::SLOT_W-1:0];
                        inc_reg   <= inc_first;
                        step_reg  <= '0;
                        state_reg <= S_READ;
                    end
                end

                // home slot read issued
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end

                // one slot examined a cycle, next read issued alongside
                S_CHECK:
                begin
                    if (slot_empty)
                    begin
                        if (mode_reg == oaht_pkg::MODE_INSERT)
                        begin
                            res_status_reg <= oaht_pkg::ST_OK;
                            res_slot_reg   <= idx_reg;
                            if (count_reg != oaht_pkg::CNT_MAX)
                            begin
                                count_reg <= count_reg + oaht_pkg::CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_reg <= oaht_pkg::ST_MISS;
                        end
                        res_probes_reg <= step_reg;
                        state_reg      <= S_DONE;
                    end
                    else if (slot_hit)
                    begin
                        res_status_reg <= oaht_pkg::ST_OK;
                        res_slot_reg   <= idx_reg;
                        res_probes_reg <= step_reg;
                        state_reg      <= S_DONE;
                    end
                    else if (last_step)
                    begin
                        res_status_reg <= oaht_pkg::ST_FULL;
                        res_probes_reg <= n_eff;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + oaht_pkg::CNT_W'(1);
                        idx_reg  <= idx_next;
                        inc_reg  <= inc_next;
                    end
                end

                // hand the result to the output register once it is free
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= res_status_reg;
                        rsp_slot_reg   <= res_slot_reg;
                        rsp_probes_reg <= res_probes_reg;
                        rsp_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/oaht_checker.sv @@
// port-level checks of the hash table, bound to the top level
// depends on oaht_pkg and open_addressing_hash_table
module oaht_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [1:0]                  rsp_status,
    input logic [oaht_pkg::SLOT_W-1:0] rsp_slot,
    input logic [oaht_pkg::CNT_W-1:0]  rsp_probes
);

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot) && $stable(rsp_probes))
        else $error("result changed while stalled");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while previous one in progress");

    // zero key touches nothing
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == oaht_pkg::ST_ZERO |-> rsp_slot == '0 && rsp_probes == '0)
        else $error("zero key result carries slot or probes");

    // miss and full report no slot
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == oaht_pkg::ST_MISS || rsp_status == oaht_pkg::ST_FULL)
            |-> rsp_slot == '0)
        else $error("slot reported on miss or full");

    // a full table was walked over at least one slot
    a_full_probes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == oaht_pkg::ST_FULL |-> rsp_probes != '0)
        else $error("table full with no probes");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot),
    .rsp_probes (rsp.probes)
);
